// File: rtl/chrl_pkg.sv
// shared types and fixed field widths for the hash ring lookup block
// no dependencies; used by every module of the block
`default_nettype none

package chrl_pkg;

	localparam int KEY_W = 64;
	localparam int IDX_W = 10;
	localparam int HOST_PORT_W = 8;
	localparam int ATTEMPT_W = 16;
	localparam int CNT_REG_W = 11;
	// wide enough to compare any index or count against the ring depth
	localparam int CMP_W = 21;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic write;
		logic probe;
		logic compare;
		logic finish;
		logic out_load;
	} chrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic count_zero;
		logic probe_end;
		logic hit;
		logic mod_done;
	} chrl_sts_t;

endpackage

`default_nettype wire

// File: rtl/chrl_rem.sv
// iterative remainder unit, one quotient bit per cycle
// depends on chrl_pkg for the attempt width
`default_nettype none

module chrl_rem #(
	parameter int CW = 11
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [chrl_pkg::ATTEMPT_W-1:0] dividend,
	input  wire logic [CW-1:0]                  divisor,
	output logic                                busy,
	output logic [CW-1:0]                       rem
);

	localparam int NW = $clog2(chrl_pkg::ATTEMPT_W + 1);

	logic [NW-1:0]                  cnt_q;
	logic [chrl_pkg::ATTEMPT_W-1:0] num_q;
	logic [CW-1:0]                  div_q;
	logic [CW-1:0]                  rem_q;
	logic [CW:0]                    trial;

	assign trial = {rem_q, num_q[chrl_pkg::ATTEMPT_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= NW'(chrl_pkg::ATTEMPT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, div_q}) begin
				rem_q <= CW'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[CW-1:0];
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign rem = rem_q;

endmodule

`default_nettype wire

// File: rtl/chrl_dp.sv
// datapath: ring memories, search bounds, offset reduction and result register
// depends on chrl_pkg and chrl_rem
`default_nettype none

module chrl_dp #(
	parameter int RING_DEPTH = 1024,
	parameter int HOST_ID_BITS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire chrl_pkg::chrl_cmd_t              cmd,
	output chrl_pkg::chrl_sts_t                   sts,
	input  wire logic                             cfg_we,
	input  wire logic [chrl_pkg::CNT_REG_W-1:0]   cfg_data,
	input  wire logic [chrl_pkg::IDX_W-1:0]       entry_index,
	input  wire logic [chrl_pkg::KEY_W-1:0]       entry_hash,
	input  wire logic [chrl_pkg::HOST_PORT_W-1:0] entry_host,
	input  wire logic [chrl_pkg::KEY_W-1:0]       key_hash,
	input  wire logic [chrl_pkg::ATTEMPT_W-1:0]   attempt,
	output logic                                  found,
	output logic [chrl_pkg::HOST_PORT_W-1:0]      chosen_host,
	output logic [chrl_pkg::IDX_W-1:0]            chosen_position
);

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int SW = CW + 1;

	logic [chrl_pkg::KEY_W-1:0]  hash_mem [RING_DEPTH];
	logic [HOST_ID_BITS-1:0]     host_mem [RING_DEPTH];

	logic [chrl_pkg::CNT_REG_W-1:0] ring_count_q;
	logic [CW-1:0]                  cnt_eff;
	logic [CW-1:0]                  cnt_q;
	logic [chrl_pkg::KEY_W-1:0]     key_q;
	logic signed [SW-1:0]           low_q;
	logic signed [SW-1:0]           high_q;
	logic signed [SW:0]             msum;
	logic [CW-1:0]                  mid;
	logic [CW-1:0]                  mid_q;
	logic                           mid_zero_q;
	logic [AW-1:0]                  pos_q;
	logic [AW-1:0]                  pos_fin_q;
	logic [CW:0]                    pos_sum;
	logic                           found_q;
	logic [chrl_pkg::KEY_W-1:0]     here_rd;
	logic [chrl_pkg::KEY_W-1:0]     prev_rd;
	logic [chrl_pkg::KEY_W-1:0]     prev_eff;
	logic [HOST_ID_BITS-1:0]        host_rd;
	logic                           idx_ok;
	logic                           rem_busy;
	logic [CW-1:0]                  rem;
	logic                           found_out_q;
	logic [chrl_pkg::HOST_PORT_W-1:0] host_out_q;
	logic [chrl_pkg::IDX_W-1:0]       pos_out_q;

	// count register, saturated to the ring depth on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q <= '0;
		end else if (cfg_we) begin
			ring_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (chrl_pkg::CMP_W'(ring_count_q) > chrl_pkg::CMP_W'(RING_DEPTH)) begin
			cnt_eff = CW'(RING_DEPTH);
		end else begin
			cnt_eff = CW'(ring_count_q);
		end
	end

	assign idx_ok = chrl_pkg::CMP_W'(entry_index) < chrl_pkg::CMP_W'(RING_DEPTH);

	// midpoint of the current bounds, valid while low <= high
	assign msum = {low_q[SW-1], low_q} + {high_q[SW-1], high_q};
	assign mid = CW'(msum >>> 1);

	// ring memories: one write port, hash has two read ports (mid and mid - 1)
	always_ff @(posedge clk) begin
		if (cmd.write && idx_ok) begin
			hash_mem[AW'(entry_index)] <= entry_hash;
			host_mem[AW'(entry_index)] <= HOST_ID_BITS'(entry_host);
		end
		here_rd <= hash_mem[AW'(mid)];
		prev_rd <= hash_mem[AW'(mid - CW'(1))];
		host_rd <= host_mem[pos_fin_q];
	end

	assign prev_eff = mid_zero_q ? '0 : prev_rd;

	assign sts.count_zero = (ring_count_q == '0);
	assign sts.probe_end = (low_q > high_q) || (mid == cnt_q);
	assign sts.hit = (key_q <= here_rd) && (key_q > prev_eff);

	// attempt offset reduced modulo the count alongside the search
	chrl_rem #(
		.CW(CW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (attempt),
		.divisor  (cnt_eff),
		.busy     (rem_busy),
		.rem      (rem)
	);

	assign sts.mod_done = !rem_busy;

	// pos < count and rem < count, so one subtract folds the sum
	assign pos_sum = (CW + 1)'(pos_q) + (CW + 1)'(rem);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_hash;
			cnt_q <= cnt_eff;
			low_q <= '0;
			high_q <= $signed({1'b0, cnt_eff});
			found_q <= (cnt_eff != '0);
		end
		if (cmd.probe) begin
			mid_q <= mid;
			mid_zero_q <= (mid == '0);
			if (sts.probe_end) begin
				pos_q <= '0;
			end
		end
		if (cmd.compare) begin
			if (sts.hit) begin
				pos_q <= AW'(mid_q);
			end else if (here_rd < key_q) begin
				low_q <= $signed({1'b0, mid_q} + SW'(1));
			end else begin
				high_q <= $signed({1'b0, mid_q} - SW'(1));
			end
		end
		if (cmd.finish) begin
			if (pos_sum >= (CW + 1)'(cnt_q)) begin
				pos_fin_q <= AW'(pos_sum - (CW + 1)'(cnt_q));
			end else begin
				pos_fin_q <= AW'(pos_sum);
			end
		end
		if (cmd.out_load) begin
			found_out_q <= found_q;
			host_out_q <= found_q ? chrl_pkg::HOST_PORT_W'(host_rd) : '0;
			pos_out_q <= found_q ? chrl_pkg::IDX_W'(pos_fin_q) : '0;
		end
	end

	assign found = found_out_q;
	assign chosen_host = host_out_q;
	assign chosen_position = pos_out_q;

	a_compare_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compare |-> (low_q <= high_q))
		else $error("compare step with crossed bounds");

	a_finish_mod_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !rem_busy)
		else $error("offset applied before remainder is ready");

	a_final_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> ((CW + 1)'(pos_fin_q) < (CW + 1)'(cnt_q)))
		else $error("final position outside the ring");

endmodule

`default_nettype wire

// File: rtl/chrl_ctrl.sv
// controller state machine for writes, the search loop and result handoff
// depends on chrl_pkg for the command and status structs
`default_nettype none

module chrl_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                kind,
	input  wire logic                out_stall,
	input  wire chrl_pkg::chrl_sts_t sts,
	output logic                     in_stall,
	output logic                     out_valid,
	output chrl_pkg::chrl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE,
		ST_FINISH,
		ST_HOSTRD,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	assign cmd.load = accept && kind;
	assign cmd.write = accept && !kind;
	assign cmd.probe = (state_q == ST_PROBE);
	assign cmd.compare = (state_q == ST_COMPARE);
	assign cmd.finish = (state_q == ST_FINISH) && sts.mod_done;
	assign cmd.out_load = (state_q == ST_RESULT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= sts.count_zero ? ST_RESULT : ST_PROBE;
					end
				end
				ST_PROBE: begin
					state_q <= sts.probe_end ? ST_FINISH : ST_COMPARE;
				end
				ST_COMPARE: begin
					state_q <= sts.hit ? ST_FINISH : ST_PROBE;
				end
				ST_FINISH: begin
					if (sts.mod_done) begin
						state_q <= ST_HOSTRD;
					end
				end
				ST_HOSTRD: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_lookup_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind) |=> in_stall)
		else $error("lookup accepted but controller stayed idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESULT))
		else $error("result raised outside the result state");

endmodule

`default_nettype wire

// File: rtl/consistent_hash_ring_lookup_top.sv
// top level of the consistent hash ring lookup block
// depends on chrl_pkg, chrl_ctrl, chrl_dp (and chrl_rem inside the datapath)
`default_nettype none

// Ring lookup engine. Software loads the ring through write requests (kind 0),
// one entry per request, in ascending hash order, and sets the number of live
// entries through the cfg port (ring_count, saturated to RING_DEPTH). A lookup
// request (kind 1) binary-searches the first ring_count entries for the first
// hash not below key_hash, wrapping to position 0 when the key is past the top
// or the bounds cross, then adds attempt modulo ring_count and returns the host
// stored there. An empty ring returns found = 0 with zero host and position.
// A write request leaves the controller idle, so the next request can follow
// right away. A lookup steps through probe and compare states: each compare
// step first reads hash[mid] and hash[mid - 1] from the two-port ring memory
// and then compares and narrows the bounds, and a full 1024-entry ring needs
// at most 11 compares. The attempt offset is reduced by a bit-serial remainder
// unit that runs alongside the search; the finish step waits for it, then the
// host is read and the output register is loaded. An empty ring goes straight
// to the result step. One lookup is in flight at a time; a finished result
// waits in the output register, so a new request is taken while it is still
// stalled. The ring memories have no reset; only entries that were written may
// be reached by a lookup. cfg writes are always ready and should be issued only
// while no lookup is active.
module consistent_hash_ring_lookup_top #(
	parameter int RING_DEPTH = 1024,
	parameter int HOST_ID_BITS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             kind,
	input  wire logic [chrl_pkg::IDX_W-1:0]       entry_index,
	input  wire logic [chrl_pkg::KEY_W-1:0]       entry_hash,
	input  wire logic [chrl_pkg::HOST_PORT_W-1:0] entry_host,
	input  wire logic [chrl_pkg::KEY_W-1:0]       key_hash,
	input  wire logic [chrl_pkg::ATTEMPT_W-1:0]   attempt,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  found,
	output logic [chrl_pkg::HOST_PORT_W-1:0]      chosen_host,
	output logic [chrl_pkg::IDX_W-1:0]            chosen_position,
	// ring_count write port
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [chrl_pkg::CNT_REG_W-1:0]   cfg_data
);

	chrl_pkg::chrl_cmd_t cmd;
	chrl_pkg::chrl_sts_t sts;

	// single register, always able to take a write
	assign cfg_ready = 1'b1;

	// sequencing of requests, search steps and result handoff
	chrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// ring storage, search bounds, offset unit and result register
	chrl_dp #(
		.RING_DEPTH   (RING_DEPTH),
		.HOST_ID_BITS (HOST_ID_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.entry_index     (entry_index),
		.entry_hash      (entry_hash),
		.entry_host      (entry_host),
		.key_hash        (key_hash),
		.attempt         (attempt),
		.found           (found),
		.chosen_host     (chosen_host),
		.chosen_position (chosen_position)
	);

endmodule

`default_nettype wire
